// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the matcher top
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/enm_pkg.sv -----
// ----------------------------------------------------------------------------
// enm_pkg
// Shared widths, codes and control structs of the epsilon NFA matcher
// ----------------------------------------------------------------------------
package enm_pkg;

    localparam int KIND_W = 2;
    localparam int STATE_W = 5;
    localparam int SYM_W = 8;
    localparam int MASK_W = 32;
    localparam int CFG_IDX_W = 1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic accept;      // input transfer, latch fields
        logic clear_wr;    // write zero at clear pointer
        logic load_wr;     // write loaded row
        logic cur_start;   // cur = start state bit
        logic cur_active;  // cur = active set
        logic cur_acc;     // cur = accumulator
        logic act_zero;    // active set = 0
        logic act_cur;     // active set = cur
        logic sweep_go;    // start a row sweep
        logic sweep_eps;   // sweep uses epsilon rows
        logic out_load;    // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic clear_last;
        logic start_ok;
        logic sweep_fin;
        logic acc_eq_cur;
        logic out_free;
        logic busy;
    } t_stat;

endpackage

// ----- rtl/enm_in_if.sv -----
// ----------------------------------------------------------------------------
// enm_in_if
// Input item channel
// ----------------------------------------------------------------------------
interface enm_in_if;
    import enm_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [STATE_W-1:0]  row_state;
    logic [SYM_W-1:0]    row_symbol;
    logic [MASK_W-1:0]   row_targets;
    logic [SYM_W-1:0]    symbol;

    modport source (output valid, kind, row_state, row_symbol, row_targets, symbol,
                    input ready);
    modport sink (input valid, kind, row_state, row_symbol, row_targets, symbol,
                  output ready);
endinterface

// ----- rtl/enm_out_if.sv -----
// ----------------------------------------------------------------------------
// enm_out_if
// Result channel
// ----------------------------------------------------------------------------
interface enm_out_if;
    import enm_pkg::*;

    logic               valid;
    logic               ready;
    logic               accepted;
    logic [MASK_W-1:0]  active_states;

    modport source (output valid, accepted, active_states, input ready);
    modport sink (input valid, accepted, active_states, output ready);
endinterface

// ----- rtl/enm_ram.sv -----
// ----------------------------------------------------------------------------
// enm_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module enm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/enm_datapath.sv -----
// ----------------------------------------------------------------------------
// enm_datapath
// Transition store, sweep engine, active set and output register
// ----------------------------------------------------------------------------
module enm_datapath #(
    parameter int NUM_STATES = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  enm_pkg::t_cmd                      i_cmd,
    output enm_pkg::t_stat                     o_stat,
    input  logic                               i_cfg_we,
    input  logic [enm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [enm_pkg::MASK_W-1:0]         i_cfg_data,
    enm_in_if.sink                             i_in,
    enm_out_if.source                          o_out
);
    import enm_pkg::*;

    localparam int LIVE = (NUM_STATES < 32) ? NUM_STATES : 32;
    localparam int SYM_COUNT = 1 << SYMBOL_BITS;
    localparam int DEPTH = NUM_STATES * SYM_COUNT;
    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW - SYMBOL_BITS;
    localparam int LW = $clog2(LIVE);
    localparam logic [MASK_W-1:0] LIVE_MASK =
        (LIVE >= 32) ? {MASK_W{1'b1}} : ((32'd1 << LIVE) - 32'd1);

    logic [MASK_W-1:0]  r_accept_mask;
    logic [STATE_W-1:0] r_start_state;
    logic [KIND_W-1:0]  r_kind;
    logic [STATE_W-1:0] r_row_state;
    logic [SYM_W-1:0]   r_row_symbol;
    logic [MASK_W-1:0]  r_row_targets;
    logic [SYM_W-1:0]   r_symbol;
    logic [MASK_W-1:0]  r_active;
    logic [MASK_W-1:0]  r_cur;
    logic [MASK_W-1:0]  r_acc;
    logic [AW-1:0]      r_clr;
    logic [LW-1:0]      r_s;
    logic               r_issue;
    logic               r_eps;
    logic               r_rd_v;
    logic [LW-1:0]      r_rd_s;
    logic               r_fin;
    logic               r_out_valid;
    logic               r_out_acc;
    logic [MASK_W-1:0]  r_out_set;

    logic                   row_ok;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [MASK_W-1:0]      ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [MASK_W-1:0]      ram_rdata;
    logic [SYMBOL_BITS-1:0] sym_sel;
    logic                   last_s;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_mask <= '0;
            r_start_state <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACCEPT_MASK: r_accept_mask <= i_cfg_data;
                CFG_START_STATE: r_start_state <= i_cfg_data[STATE_W-1:0];
                default: ;
            endcase
        end
    end

    // item fields latched at input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind        <= i_in.kind;
            r_row_state   <= i_in.row_state;
            r_row_symbol  <= i_in.row_symbol;
            r_row_targets <= i_in.row_targets;
            r_symbol      <= i_in.symbol;
        end
    end

    // store write mux: clearing pass or row load
    assign row_ok    = {2'b00, r_row_state} < 7'(NUM_STATES);
    assign ram_we    = i_cmd.clear_wr || (i_cmd.load_wr && row_ok);
    assign ram_waddr = i_cmd.clear_wr ? r_clr
                                      : {SW'(r_row_state), r_row_symbol[SYMBOL_BITS-1:0]};
    assign ram_wdata = i_cmd.clear_wr ? '0 : (r_row_targets & LIVE_MASK);

    // sweep read address
    assign sym_sel   = r_eps ? '0 : r_symbol[SYMBOL_BITS-1:0];
    assign ram_raddr = {SW'(r_s), sym_sel};
    assign last_s    = (r_s == LW'(LIVE - 1));

    enm_ram #(
        .WIDTH (MASK_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // clear pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // sweep control: one row read issued per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_rd_v  <= 1'b0;
            r_fin   <= 1'b0;
            r_eps   <= 1'b0;
            r_s     <= '0;
        end else begin
            r_rd_v <= r_issue;
            r_fin  <= r_rd_v && (r_rd_s == LW'(LIVE - 1));
            if (i_cmd.sweep_go) begin
                r_issue <= 1'b1;
                r_eps   <= i_cmd.sweep_eps;
                r_s     <= '0;
            end else if (r_issue) begin
                r_s <= r_s + LW'(1);
                if (last_s) begin
                    r_issue <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_s <= r_s;
    end

    // accumulator, current set and active set
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_go) begin
            r_acc <= i_cmd.sweep_eps ? r_cur : '0;
        end else if (r_rd_v && r_cur[r_rd_s]) begin
            r_acc <= r_acc | ram_rdata;
        end
        if (i_cmd.cur_start) begin
            r_cur <= 32'd1 << r_start_state;
        end else if (i_cmd.cur_active) begin
            r_cur <= r_active;
        end else if (i_cmd.cur_acc) begin
            r_cur <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.act_zero) begin
            r_active <= '0;
        end else if (i_cmd.act_cur) begin
            r_active <= r_cur & LIVE_MASK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_acc <= |(r_active & r_accept_mask);
            r_out_set <= r_active;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out_acc;
    assign o_out.active_states = r_out_set;

    // status back to the controller
    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.clear_last = (r_clr == AW'(DEPTH - 1));
        o_stat.start_ok   = {1'b0, r_start_state} < 6'(LIVE);
        o_stat.sweep_fin  = r_fin;
        o_stat.acc_eq_cur = (r_acc == r_cur);
        o_stat.out_free   = !r_out_valid || o_out.ready;
        o_stat.busy       = r_issue || r_rd_v;
    end
endmodule

// ----- rtl/enm_ctrl.sv -----
// ----------------------------------------------------------------------------
// enm_ctrl
// Sequencer for clearing, loading, stepping and closure sweeps
// ----------------------------------------------------------------------------
module enm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  enm_pkg::t_stat  i_stat,
    output enm_pkg::t_cmd   o_cmd
);
    import enm_pkg::*;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DECODE   = 3'd2;
    localparam logic [2:0] ST_GO_SYM   = 3'd3;
    localparam logic [2:0] ST_WAIT_SYM = 3'd4;
    localparam logic [2:0] ST_GO_EPS   = 3'd5;
    localparam logic [2:0] ST_WAIT_EPS = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.kind)
                    KIND_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state = ST_DONE;
                    end
                    KIND_START: begin
                        if (i_stat.start_ok) begin
                            o_cmd.cur_start = 1'b1;
                            n_state = ST_GO_EPS;
                        end else begin
                            o_cmd.act_zero = 1'b1;
                            n_state = ST_DONE;
                        end
                    end
                    KIND_SYMBOL: begin
                        o_cmd.cur_active = 1'b1;
                        n_state = ST_GO_SYM;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_GO_SYM: begin
                o_cmd.sweep_go = 1'b1;
                n_state = ST_WAIT_SYM;
            end
            ST_WAIT_SYM: begin
                if (i_stat.sweep_fin) begin
                    o_cmd.cur_acc = 1'b1;
                    n_state = ST_GO_EPS;
                end
            end
            ST_GO_EPS: begin
                o_cmd.sweep_go  = 1'b1;
                o_cmd.sweep_eps = 1'b1;
                n_state = ST_WAIT_EPS;
            end
            ST_WAIT_EPS: begin
                if (i_stat.sweep_fin) begin
                    if (i_stat.acc_eq_cur) begin
                        o_cmd.act_cur = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.cur_acc = 1'b1;
                        n_state = ST_GO_EPS;
                    end
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- rtl/epsilon_nfa_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// epsilon_nfa_matcher_unit
// Bit-vector epsilon NFA simulation over a RAM transition store
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  i_in      in   kind, row_state, row_symbol, row_targets, symbol
//  o_out     out  accepted, active_states
//  i_cfg_*   in   accept_mask (index 0), start_state (index 1)
//
//  after reset a clearing pass writes NUM_STATES * 2^SYMBOL_BITS rows (8192
//  at defaults); no input transfer is taken until it ends
//  load and unused items go from decode straight to the result register; a row
//  sweep reads min(NUM_STATES,32) rows, one per cycle, through the RAM read port
//  a symbol item is one sweep plus one per closure round, a start item one
//  per round (up to 32 rounds); a waiting result holds the unit until transfer
// ----------------------------------------------------------------------------
module epsilon_nfa_matcher_unit #(
    parameter int NUM_STATES = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [enm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [enm_pkg::MASK_W-1:0]     i_cfg_data,
    enm_in_if.sink                         i_in,
    enm_out_if.source                      o_out
);
    import enm_pkg::*;

`include "assert_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    enm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    enm_datapath #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out)
    );

    // checks
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, (!o_out.valid || o_out.ready))
    `ASSERT_IMPL(a_sweep_idle, i_clk, i_rst_n, cmd.sweep_go, !stat.busy)
    `ASSERT_IMPL(a_clear_blocks, i_clk, i_rst_n, cmd.clear_wr, !i_in.ready)
    `ASSERT_NEXT(a_out_after_load, i_clk, i_rst_n, cmd.out_load, o_out.valid)
endmodule

// ----- tb/tb_epsilon_nfa_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// tb_epsilon_nfa_matcher_unit
// Self-checking bench for the epsilon NFA matcher
// ----------------------------------------------------------------------------
//  Loads small automata into the transition store and runs start and symbol
//  items through them. A bit-vector model of the active set and the store
//  predicts results; directed rows may carry their own expected values. A
//  directed table comes first, then random phases under several accept
//  masks and start states, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_epsilon_nfa_matcher_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import enm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int NSTATES = 32;
    localparam int NSYMS = 256;
    localparam int SETTLE_CYCLES = 1300;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] rs;
        logic [SYM_W-1:0]   rsym;
        logic [MASK_W-1:0]  rt;
        logic [SYM_W-1:0]   sym;
    } nfa_item_t;

    typedef struct {
        logic              acc;
        logic [MASK_W-1:0] set;
    } match_t;

    typedef struct {
        nfa_item_t         it;
        bit                typed;
        logic              acc;
        logic [MASK_W-1:0] set;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [MASK_W-1:0]    i_cfg_data;

    enm_in_if  in_ch ();
    enm_out_if out_ch ();

    epsilon_nfa_matcher_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // model state
    logic [MASK_W-1:0]  row_mem [NSTATES][NSYMS];
    logic [MASK_W-1:0]  active_q;
    logic [MASK_W-1:0]  accept_q;
    logic [STATE_W-1:0] start_q;
    match_t             pending_q[$];
    int                 err_cnt = 0;
    int                 burst_left = 0;
    bit                 tx_calm = 0;
    int                 rx_cycle = 0;

    // OR of the rows for one symbol over every state in a set
    function automatic logic [MASK_W-1:0] fan_out(logic [MASK_W-1:0] set,
                                                  logic [SYM_W-1:0] sym);
        logic [MASK_W-1:0] acc;
        acc = '0;
        for (int s = 0; s < NSTATES; s++) begin
            if (set[s]) acc |= row_mem[s][sym];
        end
        return acc;
    endfunction

    function automatic logic [MASK_W-1:0] eps_close(logic [MASK_W-1:0] set);
        logic [MASK_W-1:0] cur, nxt;
        cur = set;
        nxt = cur | fan_out(cur, '0);
        while (nxt != cur) begin
            cur = nxt;
            nxt = cur | fan_out(cur, '0);
        end
        return cur;
    endfunction

    function automatic match_t advance(nfa_item_t it);
        match_t r;
        case (it.kind)
            KIND_LOAD:   row_mem[it.rs][it.rsym] = it.rt;
            KIND_START:  active_q = eps_close(MASK_W'(1) << start_q);
            KIND_SYMBOL: active_q = eps_close(fan_out(active_q, it.sym));
            default: ;
        endcase
        r.acc = |(active_q & accept_q);
        r.set = active_q;
        return r;
    endfunction

    task automatic note_error(string what, logic [MASK_W-1:0] exp_v,
                              logic [MASK_W-1:0] got_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
    endtask

    // result side: the ready pattern rotates among always ready, random and periodic stall modes
    always @(posedge i_clk) begin
        int mode;
        mode = (rx_cycle >> 8) % 4;
        rx_cycle <= rx_cycle + 1;
        case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ((rx_cycle % 7) < 2);
            default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // result transfer check
    always @(posedge i_clk) begin
        match_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                note_error("unexpected result", '0, out_ch.active_states);
            end else begin
                e = pending_q.pop_front();
                if (out_ch.accepted !== e.acc)
                    note_error("accepted", MASK_W'(e.acc), MASK_W'(out_ch.accepted));
                if (out_ch.active_states !== e.set)
                    note_error("active_states", e.set, out_ch.active_states);
            end
        end
    end

    // one register write, then the write port idles before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ACCEPT_MASK) accept_q = data;
        else start_q = data[STATE_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_q.size() != 0);
    endtask

    // one input transfer, then possibly a random gap when the burst ends
    task automatic send_item(nfa_item_t it, bit typed, logic eacc, logic [MASK_W-1:0] eset);
        match_t m;
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.kind <= it.kind;
        in_ch.row_state <= it.rs;
        in_ch.row_symbol <= it.rsym;
        in_ch.row_targets <= it.rt;
        in_ch.symbol <= it.sym;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        m = advance(it);
        if (typed) begin
            m.acc = eacc;
            m.set = eset;
        end
        pending_q.push_back(m);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = tx_calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic set_phase(logic [MASK_W-1:0] acc_mask, logic [STATE_W-1:0] st);
        drain();
        repeat (40) @(posedge i_clk);
        write_reg(CFG_ACCEPT_MASK, acc_mask);
        write_reg(CFG_START_STATE, MASK_W'(st));
    endtask

    function automatic nfa_item_t mk(logic [KIND_W-1:0] k, logic [STATE_W-1:0] rs,
                                     logic [SYM_W-1:0] rsym, logic [MASK_W-1:0] rt,
                                     logic [SYM_W-1:0] sym);
        nfa_item_t it;
        it.kind = k;
        it.rs = rs;
        it.rsym = rsym;
        it.rt = rt;
        it.sym = sym;
        return it;
    endfunction

    function automatic logic [MASK_W-1:0] sparse_mask();
        logic [MASK_W-1:0] m;
        m = '0;
        repeat ($urandom_range(0, 3)) m[$urandom_range(0, NSTATES - 1)] = 1'b1;
        return m;
    endfunction

    function automatic nfa_item_t noise_item();
        return mk(KIND_W'($urandom_range(0, 3)), STATE_W'($urandom), SYM_W'($urandom),
                  $urandom, SYM_W'($urandom));
    endfunction

    // random phase: mix row loads over a small state pool with start, symbol and noise items
    task automatic run_phase(int n_items);
        logic [SYM_W-1:0] alpha [4];
        logic [STATE_W-1:0] pool [8];
        int sent;
        int pause_at;
        sent = 0;
        pause_at = $urandom_range(10, n_items - 10);
        tx_calm = ($urandom_range(0, 3) == 0);
        foreach (alpha[i]) alpha[i] = SYM_W'($urandom);
        alpha[0] = ($urandom_range(0, 2) == 0) ? '0 : alpha[0];
        foreach (pool[i]) pool[i] = STATE_W'($urandom);
        while (sent < n_items) begin
            int r;
            r = $urandom_range(0, 99);
            if (sent == pause_at) drain();
            if (r < 12) begin
                send_item(noise_item(), 0, 0, '0);
            end else if (r < 35) begin
                send_item(mk(KIND_LOAD, pool[$urandom_range(0, 7)],
                             ($urandom_range(0, 2) == 0) ? '0 : alpha[$urandom_range(0, 3)],
                             ($urandom_range(0, 9) == 0) ? $urandom : sparse_mask(),
                             SYM_W'($urandom)), 0, 0, '0);
            end else if (r < 45) begin
                send_item(mk(KIND_START, STATE_W'($urandom), SYM_W'($urandom), $urandom,
                             SYM_W'($urandom)), 0, 0, '0);
            end else begin
                send_item(mk(KIND_SYMBOL, STATE_W'($urandom), SYM_W'($urandom), $urandom,
                             alpha[$urandom_range(0, 3)]), 0, 0, '0);
            end
            sent++;
        end
    endtask

    dir_row_t dir_tbl [] = '{
        '{mk(KIND_UNUSED, '1, '1, '1, '1),                 1, 1'b0, 32'h0},
        '{mk(KIND_LOAD, 5'd0, 8'h00, 32'h0, 8'h00),          1, 1'b0, 32'h0},
        '{mk(KIND_START, 5'd0, 8'h00, 32'h0, 8'h00),         1, 1'b1, 32'h1},
        '{mk(KIND_LOAD, 5'd31, 8'hFF, 32'hFFFF_FFFF, 8'hFF), 1, 1'b1, 32'h1},
        '{mk(KIND_LOAD, 5'd0, 8'h00, 32'h2, 8'h00),          0, 1'b0, 32'h0},
        '{mk(KIND_LOAD, 5'd1, 8'h00, 32'h4, 8'h00),          0, 1'b0, 32'h0},
        '{mk(KIND_LOAD, 5'd2, 8'h61, 32'h8000_0000, 8'h00),  0, 1'b0, 32'h0},
        '{mk(KIND_START, 5'd0, 8'h00, 32'h0, 8'h00),         0, 1'b0, 32'h0},
        '{mk(KIND_SYMBOL, 5'd0, 8'h00, 32'h0, 8'h61),        0, 1'b0, 32'h0},
        '{mk(KIND_SYMBOL, 5'd0, 8'h00, 32'h0, 8'hFF),        0, 1'b0, 32'h0},
        '{mk(KIND_SYMBOL, 5'd0, 8'h00, 32'h0, 8'h00),        0, 1'b0, 32'h0},
        '{mk(KIND_SYMBOL, 5'd0, 8'h00, 32'h0, 8'h62),        0, 1'b0, 32'h0},
        '{mk(KIND_LOAD, 5'd31, 8'h00, 32'h1, 8'h00),         0, 1'b0, 32'h0},
        '{mk(KIND_LOAD, 5'd5, 8'h80, 32'hAAAA_5555, 8'h00),  0, 1'b0, 32'h0},
        '{mk(KIND_START, 5'd0, 8'h00, 32'h0, 8'h00),         0, 1'b0, 32'h0},
        '{mk(KIND_SYMBOL, 5'd0, 8'h00, 32'h0, 8'h61),        0, 1'b0, 32'h0},
        '{mk(KIND_SYMBOL, 5'd0, 8'h00, 32'h0, 8'h80),        0, 1'b0, 32'h0},
        '{mk(KIND_UNUSED, '0, '0, '0, '0),                   0, 1'b0, 32'h0}
    };

    // run limit
    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

    // main sequence
    initial begin
        int waited;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.row_state = '0;
        in_ch.row_symbol = '0;
        in_ch.row_targets = '0;
        in_ch.symbol = '0;
        out_ch.ready = 1'b0;
        foreach (row_mem[s, y]) row_mem[s][y] = '0;
        active_q = '0;
        accept_q = '0;
        start_q = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(CFG_ACCEPT_MASK, 32'h8000_0001);
        write_reg(CFG_START_STATE, '0);

        // directed table
        foreach (dir_tbl[i])
            send_item(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].acc, dir_tbl[i].set);

        // random phases under several register settings
        set_phase(32'hFFFF_FFFF, 5'd31);
        run_phase(90);
        set_phase(32'h0, 5'd0);
        run_phase(90);
        for (int p = 0; p < 4; p++) begin
            set_phase($urandom, STATE_W'($urandom));
            run_phase(88);
        end

        // end of stimulus
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_q.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/enm_pkg.sv
rtl/enm_in_if.sv
rtl/enm_out_if.sv
rtl/enm_ram.sv
rtl/enm_datapath.sv
rtl/enm_ctrl.sv
rtl/epsilon_nfa_matcher_unit.sv
tb/tb_epsilon_nfa_matcher_unit.sv
